// File: rtl/core/pidtw_pkg.sv
package pidtw_pkg;

  // register indexes of the configuration port
  localparam logic [2:0] CFG_KP_START    = 3'd0;
  localparam logic [2:0] CFG_KI_START    = 3'd1;
  localparam logic [2:0] CFG_KD_START    = 3'd2;
  localparam logic [2:0] CFG_OUT_MAX     = 3'd3;
  localparam logic [2:0] CFG_OUT_MIN     = 3'd4;
  localparam logic [2:0] CFG_TUNE_ENABLE = 3'd5;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // 0.001 and 0.0002 in Q8.24
  localparam logic signed [31:0] STEP_INIT      = 32'sd16777;
  localparam logic signed [33:0] TUNE_THRESHOLD = 34'sd3355;
  localparam logic [16:0]        BEST_INF       = 17'h1ffff;

  localparam logic signed [15:0] OUT_MAX_RST = 16'sd256;
  localparam logic signed [15:0] OUT_MIN_RST = -16'sd256;

  // step scaling divides by ten
  localparam logic [15:0] SCALE_DEN = 16'd10;

  // serial unit lengths
  localparam logic [5:0] MUL_BITS = 6'd32;
  localparam logic [5:0] DIV_BITS = 6'd36;

  // clamp to 32 bit signed
  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    if (v > 40'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -40'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

  // magnitude of a 32 bit signed value
  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    logic signed [31:0] n;
    n = -v;
    return v[31] ? n[31:0] : v[31:0];
  endfunction

endpackage

// File: rtl/core/pidtw_if.sv
interface pidtw_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] error;
  logic [15:0] step_time;

  modport source (output valid, output error, output step_time, input ready);
  modport sink (input valid, input error, input step_time, output ready);
endinterface

interface pidtw_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] drive;

  modport source (output valid, output drive, input ready);
  modport sink (input valid, input drive, output ready);
endinterface

// File: rtl/core/pid_controller_twiddle_tuned.sv
// PID controller with twiddle gain tuning.
// Input channel in_i carries a signed Q8.8 error and an unsigned Q4.12 time
// step; output channel out_o returns one clamped signed Q8.8 drive value per
// transfer. Configuration goes through a plain write port (cfg_we_i,
// cfg_idx_i, cfg_data_i); writing a start gain also loads the live gain.
// One item is worked at a time. All products run through one shift-add
// multiplier that takes one bit per cycle, and all quotients through one
// restoring divider that takes one bit per cycle.
// A plain PID item needs four products and one quotient (a zero time step
// skips the quotient); the block is ready for the next input in the cycle
// after the result is loaded.
// A tuning step adds one product and then either a gain back-off or a step
// rescale through the divider.
// Reset clears gains to zero, steps to 0.001, best score to infinity, the
// limits to +-1.0 and tuning off. A finished result sits in an output
// register; while the receiver stalls, the next item is still taken and
// worked, and it waits before its own result until that register is free.
module pid_controller_twiddle_tuned (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [pidtw_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [pidtw_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  pidtw_in_if.sink                              in_i,
  pidtw_out_if.source                           out_o
);

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_TSQ  = 14'b00000000000010,
    S_TW   = 14'b00000000000100,
    S_TSUB = 14'b00000000001000,
    S_TFIN = 14'b00000000010000,
    S_PDIV = 14'b00000000100000,
    S_PSLP = 14'b00000001000000,
    S_PINT = 14'b00000010000000,
    S_PP   = 14'b00000100000000,
    S_PD   = 14'b00001000000000,
    S_PI   = 14'b00010000000000,
    S_OUT  = 14'b00100000000000,
    S_MUL  = 14'b01000000000000,
    S_DIV  = 14'b10000000000000
  } state_e;

  state_e state_q, ret_q;

  // configuration and controller state
  logic signed [15:0] out_max_q, out_min_q;
  logic               tune_en_q;
  logic signed [31:0] gains_q [3];
  logic signed [31:0] steps_q [3];
  logic [1:0]         idx_q;
  logic               phase_q;
  logic [16:0]        best_q;
  logic signed [15:0] last_q;
  logic signed [31:0] sum_q;
  logic signed [31:0] slope_q;

  // item registers
  logic signed [15:0] e_q;
  logic [15:0]        t_q;
  logic signed [65:0] ctl_q;
  logic               out_valid_q;
  logic [15:0]        drive_q;

  // serial multiplier
  logic [31:0] mul_a_q;
  logic [63:0] mul_p_q;
  logic        mul_neg_q;
  // serial divider
  logic [35:0] div_n_q;
  logic [15:0] div_r_q;
  logic [15:0] div_d_q;
  logic        div_neg_q;
  logic [5:0]  cnt_q;

  // unit results
  logic signed [63:0] mul_res;
  logic signed [36:0] div_res;
  assign mul_res = mul_neg_q ? -$signed(mul_p_q) : $signed(mul_p_q);
  assign div_res = div_neg_q ? -$signed({1'b0, div_n_q}) : $signed({1'b0, div_n_q});

  // multiplier and divider steps
  logic [32:0] mul_sum;
  logic [16:0] div_rs;
  logic        div_ge;
  assign mul_sum = {1'b0, mul_p_q[63:32]} + (mul_p_q[0] ? {1'b0, mul_a_q} : 33'd0);
  assign div_rs  = {div_r_q, div_n_q[35]};
  assign div_ge  = div_rs >= {1'b0, div_d_q};

  // tuning decision
  logic signed [33:0] sum_dp;
  logic               tune_go;
  assign sum_dp  = 34'(steps_q[0]) + 34'(steps_q[1]) + 34'(steps_q[2]);
  assign tune_go = tune_en_q && (sum_dp > pidtw_pkg::TUNE_THRESHOLD);

  logic signed [31:0] g_sel, dp_sel;
  logic [15:0]        score;
  logic               better;
  assign g_sel  = gains_q[idx_q];
  assign dp_sel = steps_q[idx_q];
  assign score  = mul_res[31:16];
  assign better = {1'b0, score} < best_q;

  // scaled step magnitude for x1.1 or x0.9
  logic signed [35:0] dpx, dp_scaled;
  logic [35:0]        dp_mag;
  logic signed [35:0] dp_neg;
  assign dpx       = 36'(dp_sel);
  assign dp_scaled = better ? (dpx <<< 3) + (dpx <<< 1) + dpx : (dpx <<< 3) + dpx;
  assign dp_neg    = -dp_scaled;
  assign dp_mag    = dp_scaled[35] ? dp_neg[35:0] : dp_scaled[35:0];

  // derivative numerator
  logic signed [16:0] diff;
  logic signed [28:0] num, num_neg;
  logic [28:0]        num_mag;
  assign diff    = 17'(e_q) - 17'(last_q);
  assign num     = 29'(diff) <<< 12;
  assign num_neg = -num;
  assign num_mag = num[28] ? num_neg[28:0] : num[28:0];

  // multiplier operand select
  logic               mul_go;
  logic signed [31:0] mul_x, mul_y;
  state_e             mul_ret;
  always_comb begin
    mul_go  = 1'b0;
    mul_x   = 32'(e_q);
    mul_y   = 32'(e_q);
    mul_ret = S_TW;
    unique case (state_q)
      S_TSQ: begin
        mul_go = 1'b1;
      end
      S_PSLP: begin
        mul_go  = 1'b1;
        mul_y   = $signed({16'b0, t_q});
        mul_ret = S_PINT;
      end
      S_PINT: begin
        mul_go  = 1'b1;
        mul_x   = gains_q[0];
        mul_ret = S_PP;
      end
      S_PP: begin
        mul_go  = 1'b1;
        mul_x   = gains_q[2];
        mul_y   = slope_q;
        mul_ret = S_PD;
      end
      S_PD: begin
        mul_go  = 1'b1;
        mul_x   = gains_q[1];
        mul_y   = sum_q;
        mul_ret = S_PI;
      end
      default: begin
        mul_go = 1'b0;
      end
    endcase
  end

  logic signed [39:0] int_next;
  assign int_next = 40'(sum_q) + 40'(mul_res);

  logic signed [65:0] lim_hi, lim_lo;
  assign lim_hi = 66'(out_max_q) <<< 24;
  assign lim_lo = 66'(out_min_q) <<< 24;

  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.drive = drive_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      out_max_q   <= pidtw_pkg::OUT_MAX_RST;
      out_min_q   <= pidtw_pkg::OUT_MIN_RST;
      tune_en_q   <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        gains_q[k] <= '0;
        steps_q[k] <= pidtw_pkg::STEP_INIT;
      end
      idx_q       <= '0;
      phase_q     <= 1'b0;
      best_q      <= pidtw_pkg::BEST_INF;
      last_q      <= '0;
      sum_q       <= '0;
      slope_q     <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      // configuration writes
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          pidtw_pkg::CFG_KP_START:    gains_q[0] <= $signed(cfg_data_i);
          pidtw_pkg::CFG_KI_START:    gains_q[1] <= $signed(cfg_data_i);
          pidtw_pkg::CFG_KD_START:    gains_q[2] <= $signed(cfg_data_i);
          pidtw_pkg::CFG_OUT_MAX:     out_max_q <= $signed(cfg_data_i[15:0]);
          pidtw_pkg::CFG_OUT_MIN:     out_min_q <= $signed(cfg_data_i[15:0]);
          pidtw_pkg::CFG_TUNE_ENABLE: tune_en_q <= cfg_data_i[0];
          default: ;
        endcase
      end

      // drop the result once transferred
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      // launch a product
      if (mul_go) begin
        mul_a_q   <= pidtw_pkg::mag32(mul_x);
        mul_p_q   <= {32'b0, pidtw_pkg::mag32(mul_y)};
        mul_neg_q <= mul_x[31] ^ mul_y[31];
        cnt_q     <= pidtw_pkg::MUL_BITS;
        ret_q     <= mul_ret;
        state_q   <= S_MUL;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            e_q     <= $signed(in_i.error);
            t_q     <= in_i.step_time;
            state_q <= tune_go ? S_TSQ : S_PDIV;
          end
        end
        S_TSQ: ;
        S_TW: begin
          if (better) begin
            best_q <= {1'b0, score};
          end
          if (!phase_q || !better) begin
            gains_q[idx_q] <= pidtw_pkg::sat32(40'(g_sel) + 40'(dp_sel));
          end
          if (!phase_q && !better) begin
            state_q <= S_TSUB;
          end else begin
            // scale the step by 1.1 or 0.9
            div_n_q   <= dp_mag;
            div_r_q   <= '0;
            div_d_q   <= pidtw_pkg::SCALE_DEN;
            div_neg_q <= dp_scaled[35];
            cnt_q     <= pidtw_pkg::DIV_BITS;
            ret_q     <= S_TFIN;
            state_q   <= S_DIV;
          end
        end
        S_TSUB: begin
          gains_q[idx_q] <= pidtw_pkg::sat32(40'(g_sel) - (40'(dp_sel) <<< 1));
          phase_q        <= 1'b1;
          state_q        <= S_PDIV;
        end
        S_TFIN: begin
          steps_q[idx_q] <= pidtw_pkg::sat32(40'(div_res));
          idx_q          <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
          phase_q        <= 1'b0;
          state_q        <= S_PDIV;
        end
        S_PDIV: begin
          if (t_q != '0) begin
            div_n_q   <= 36'(num_mag);
            div_r_q   <= '0;
            div_d_q   <= t_q;
            div_neg_q <= num[28];
            cnt_q     <= pidtw_pkg::DIV_BITS;
            ret_q     <= S_PSLP;
            state_q   <= S_DIV;
          end else begin
            state_q <= S_PSLP;
          end
        end
        S_PSLP: begin
          slope_q <= (t_q == '0) ? 32'sd0 : div_res[31:0];
          last_q  <= e_q;
        end
        S_PINT: begin
          sum_q <= pidtw_pkg::sat32(int_next);
        end
        S_PP: begin
          ctl_q <= 66'(mul_res);
        end
        S_PD: begin
          ctl_q <= ctl_q + 66'(mul_res);
        end
        S_PI: begin
          ctl_q   <= ctl_q + 66'(mul_res >>> 12);
          state_q <= S_OUT;
        end
        S_OUT: begin
          // hold until the output register is free
          if (!out_valid_q || out_o.ready) begin
            if (ctl_q > lim_hi) begin
              drive_q <= out_max_q;
            end else if (ctl_q < lim_lo) begin
              drive_q <= out_min_q;
            end else begin
              drive_q <= ctl_q[39:24];
            end
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        S_MUL: begin
          mul_p_q <= {mul_sum, mul_p_q[31:1]};
          cnt_q   <= cnt_q - 6'd1;
          if (cnt_q == 6'd1) begin
            state_q <= ret_q;
          end
        end
        S_DIV: begin
          div_r_q <= div_ge ? 16'(div_rs - {1'b0, div_d_q}) : div_rs[15:0];
          div_n_q <= {div_n_q[34:0], div_ge};
          cnt_q   <= cnt_q - 6'd1;
          if (cnt_q == 6'd1) begin
            state_q <= ret_q;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// File: verif/pid_controller_twiddle_tuned_tb.sv
`timescale 1ns / 100ps

module pid_controller_twiddle_tuned_tb;

  typedef struct packed {
    logic [15:0] err;
    logic [15:0] dt;
  } sample_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             cfg_we = 1'b0;
  logic [pidtw_pkg::CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [pidtw_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  pidtw_in_if  in_if ();
  pidtw_out_if out_if ();

  pid_controller_twiddle_tuned dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // mirror of the controller state
  int          gain_k [3];
  int          tweak_step [3];
  int          tune_sel;
  bit          tune_neg;
  longint      best_sq;
  longint      prev_err;
  int          integ;
  int          deriv;
  int          lim_hi;
  int          lim_lo;
  bit          tune_on;

  sample_t     pend_q [$];
  logic [15:0] drive_q [$];
  int          err_cnt = 0;
  int          result_cnt = 0;
  longint      cyc = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int clip32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  // twiddle step, PID update and clamp for one sample
  function automatic logic [15:0] predict_drive(input logic signed [15:0] err,
                                                input logic [15:0] dt);
    longint e, t, sum_dp, dp, sq, ctl, hi, lo, res;
    int i;
    e = err;
    t = dt;
    sum_dp = longint'(tweak_step[0]) + tweak_step[1] + tweak_step[2];
    if (tune_on && sum_dp > longint'(pidtw_pkg::TUNE_THRESHOLD)) begin
      i = tune_sel;
      sq = (e * e) >> 16;
      dp = tweak_step[i];
      if (!tune_neg) begin
        gain_k[i] = clip32(longint'(gain_k[i]) + dp);
        if (sq < best_sq) begin
          best_sq = sq;
          tweak_step[i] = clip32(dp * 11 / 10);
          tune_sel = (tune_sel >= 2) ? 0 : tune_sel + 1;
        end else begin
          gain_k[i] = clip32(longint'(gain_k[i]) - 2 * dp);
          tune_neg = 1'b1;
        end
      end else begin
        if (sq < best_sq) begin
          best_sq = sq;
          tweak_step[i] = clip32(dp * 11 / 10);
        end else begin
          gain_k[i] = clip32(longint'(gain_k[i]) + dp);
          tweak_step[i] = clip32(dp * 9 / 10);
        end
        tune_sel = (tune_sel >= 2) ? 0 : tune_sel + 1;
        tune_neg = 1'b0;
      end
    end
    deriv = (t > 0) ? int'((e - prev_err) * 4096 / t) : 0;
    prev_err = e;
    integ = clip32(longint'(integ) + e * t);
    ctl = longint'(gain_k[0]) * e + longint'(gain_k[2]) * deriv
        + ((longint'(gain_k[1]) * integ) >>> 12);
    hi = longint'(lim_hi) * 64'sd16777216;
    lo = longint'(lim_lo) * 64'sd16777216;
    if (ctl > hi) res = lim_hi;
    else if (ctl < lo) res = lim_lo;
    else res = ctl >>> 24;
    return res[15:0];
  endfunction

  task automatic write_reg(input logic [pidtw_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] data);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    case (idx)
      pidtw_pkg::CFG_KP_START:    gain_k[0] = int'(data);
      pidtw_pkg::CFG_KI_START:    gain_k[1] = int'(data);
      pidtw_pkg::CFG_KD_START:    gain_k[2] = int'(data);
      pidtw_pkg::CFG_OUT_MAX:     lim_hi = int'(signed'(data[15:0]));
      pidtw_pkg::CFG_OUT_MIN:     lim_lo = int'(signed'(data[15:0]));
      pidtw_pkg::CFG_TUNE_ENABLE: tune_on = data[0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic sample_t rand_sample();
    sample_t s;
    case ($urandom_range(0, 3))
      0: s.err = 16'($urandom);
      1: s.err = 16'($urandom_range(0, 32767) % 4096 - 2048);
      2: s.err = ($urandom_range(0, 1)) ? 16'h7fff - 16'($urandom_range(0, 8))
                                        : 16'h8000 + 16'($urandom_range(0, 8));
      default: s.err = 16'($urandom_range(0, 511) - 256);
    endcase
    case ($urandom_range(0, 7))
      0: s.dt = 16'h0000;
      1, 2: s.dt = 16'($urandom);
      3: s.dt = 16'($urandom_range(1, 4));
      default: s.dt = 16'($urandom_range(1, 2048));
    endcase
    return s;
  endfunction

  // push items, then hold until every result is back and the block is idle
  task automatic run_batch(input int n);
    repeat (n) pend_q.push_back(rand_sample());
    while (pend_q.size() != 0 || in_if.valid || drive_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic push_sample(input logic [15:0] e, input logic [15:0] t);
    sample_t s;
    s.err = e;
    s.dt  = t;
    pend_q.push_back(s);
  endtask

  // sender: bursts of transfers with random gaps
  int gap_left = 0;
  int burst_left = 4;
  always @(posedge clk_i) begin
    sample_t s;
    logic    nv;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        drive_q.push_back(predict_drive(in_if.error, in_if.step_time));
      end
      if (!in_if.valid || in_if.ready) begin
        nv = 1'b0;
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (pend_q.size() != 0) begin
          s = pend_q.pop_front();
          in_if.error     <= s.err;
          in_if.step_time <= s.dt;
          nv = 1'b1;
          if (burst_left <= 1) begin
            if ($urandom_range(0, 4) == 0) begin
              burst_left <= 40;
              gap_left   <= 0;
            end else begin
              burst_left <= $urandom_range(1, 12);
              gap_left   <= $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 30);
            end
          end else begin
            burst_left <= burst_left - 1;
          end
        end
        in_if.valid <= nv;
      end
    end
  end

  // receiver: random stalls and one long hold-off
  int stall_left = 0;
  int long_left = 0;
  bit long_done = 1'b0;
  always @(posedge clk_i) begin
    logic [15:0] want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        result_cnt <= result_cnt + 1;
        if (drive_q.size() == 0) begin
          $display("%0t: unexpected drive result %0d", $time, $signed(out_if.drive));
          err_cnt <= err_cnt + 1;
        end else begin
          want = drive_q.pop_front();
          if (want !== out_if.drive) begin
            $display("%0t: drive mismatch, expected %0d, actual %0d", $time,
                     $signed(want), $signed(out_if.drive));
            err_cnt <= err_cnt + 1;
          end
        end
      end
      if (!long_done && result_cnt == 600) begin
        long_done <= 1'b1;
        long_left <= 3000;
        out_if.ready <= 1'b0;
      end else if (long_left > 0) begin
        long_left <= long_left - 1;
        out_if.ready <= (long_left == 1);
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_if.ready <= (stall_left == 1);
      end else if ((cyc % 4000) < 1500 && $urandom_range(0, 5) == 0) begin
        stall_left <= $urandom_range(1, 20);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > 4000000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    in_if.valid     = 1'b0;
    in_if.error     = '0;
    in_if.step_time = '0;
    out_if.ready    = 1'b0;
    gain_k     = '{0, 0, 0};
    tweak_step = '{pidtw_pkg::STEP_INIT, pidtw_pkg::STEP_INIT, pidtw_pkg::STEP_INIT};
    tune_sel = 0;
    tune_neg = 1'b0;
    best_sq  = pidtw_pkg::BEST_INF;
    prev_err = 0;
    integ    = 0;
    deriv    = 0;
    lim_hi   = pidtw_pkg::OUT_MAX_RST;
    lim_lo   = pidtw_pkg::OUT_MIN_RST;
    tune_on  = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // defaults: field extremes, zero time step
    write_reg(pidtw_pkg::CFG_KP_START, 32'h0100_0000);
    write_reg(pidtw_pkg::CFG_KI_START, 32'h0040_0000);
    write_reg(pidtw_pkg::CFG_KD_START, 32'h0010_0000);
    push_sample(16'h7fff, 16'hffff);
    push_sample(16'h8000, 16'hffff);
    push_sample(16'h0000, 16'h0000);
    push_sample(16'h7fff, 16'h0000);
    push_sample(16'h8000, 16'h0001);
    push_sample(16'h7fff, 16'h0001);
    push_sample(16'h0100, 16'h1000);
    push_sample(16'hff00, 16'h1000);
    push_sample(16'h0001, 16'h0001);
    push_sample(16'hffff, 16'h8000);
    run_batch(200);

    // wide limits, extreme gains
    write_reg(pidtw_pkg::CFG_OUT_MAX, 32'h0000_7fff);
    write_reg(pidtw_pkg::CFG_OUT_MIN, 32'hffff_8000);
    write_reg(pidtw_pkg::CFG_KP_START, 32'h7fff_ffff);
    write_reg(pidtw_pkg::CFG_KI_START, 32'h8000_0000);
    write_reg(pidtw_pkg::CFG_KD_START, 32'h0000_0001);
    run_batch(200);

    // tuning on, small gains; unknown indexes are ignored
    write_reg(pidtw_pkg::CFG_KP_START, $urandom_range(0, 32'h0200_0000));
    write_reg(pidtw_pkg::CFG_KI_START, $urandom_range(0, 32'h0010_0000));
    write_reg(pidtw_pkg::CFG_KD_START, $urandom_range(0, 32'h0001_0000));
    write_reg(pidtw_pkg::CFG_OUT_MAX, 32'h0000_0400);
    write_reg(pidtw_pkg::CFG_OUT_MIN, 32'hffff_fc00);
    write_reg(pidtw_pkg::CFG_TUNE_ENABLE, 32'h1);
    write_reg(3'd6, 32'hffff_ffff);
    write_reg(3'd7, 32'h1234_5678);
    for (int k = 0; k < 10; k++) push_sample(16'(k * 300 - 1500), 16'h0100);
    push_sample(16'h0000, 16'h0000);
    run_batch(300);

    // crossed limits, random gains, tuning still running
    write_reg(pidtw_pkg::CFG_OUT_MAX, 32'hffff_ff00);
    write_reg(pidtw_pkg::CFG_OUT_MIN, 32'h0000_0100);
    write_reg(pidtw_pkg::CFG_KP_START, $urandom);
    write_reg(pidtw_pkg::CFG_KD_START, $urandom);
    run_batch(200);

    // tuning with extreme gains
    write_reg(pidtw_pkg::CFG_OUT_MAX, 32'h0000_2000);
    write_reg(pidtw_pkg::CFG_OUT_MIN, 32'hffff_e000);
    write_reg(pidtw_pkg::CFG_KP_START, 32'h8000_0000);
    write_reg(pidtw_pkg::CFG_KI_START, 32'h7fff_ffff);
    write_reg(pidtw_pkg::CFG_KD_START, 32'h8000_0000);
    run_batch(150);

    // tuning off again, random everything
    write_reg(pidtw_pkg::CFG_TUNE_ENABLE, 32'h0);
    write_reg(pidtw_pkg::CFG_KP_START, $urandom);
    write_reg(pidtw_pkg::CFG_KI_START, $urandom);
    write_reg(pidtw_pkg::CFG_KD_START, $urandom);
    write_reg(pidtw_pkg::CFG_OUT_MAX, $urandom);
    write_reg(pidtw_pkg::CFG_OUT_MIN, $urandom);
    run_batch(200);

    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/pidtw_pkg.sv
rtl/core/pidtw_if.sv
rtl/core/pid_controller_twiddle_tuned.sv
verif/pid_controller_twiddle_tuned_tb.sv
